/* hdl/lru_pkg.sv */
`default_nettype none

package lru_pkg;

   localparam int MAX_ENTRIES  = 16;
   localparam int PAGE_BITS    = 20;
   localparam int PROCESS_BITS = 10;

   localparam int IDX_BITS = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_BITS = PAGE_BITS + PROCESS_BITS;
   localparam int CAP_BITS = 5;
   localparam int OCC_BITS = 5;

   localparam int REQ_BITS = ((KEY_BITS + 7) / 8) * 8;
   localparam int RSP_RAW  = 2 + KEY_BITS + OCC_BITS;
   localparam int RSP_BITS = ((RSP_RAW + 7) / 8) * 8;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(MAX_ENTRIES);

   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

`default_nettype wire

/* hdl/lru_ram.sv */
`default_nettype none

module lru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/lru_page_replacement_list.sv */
`default_nettype none

// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tdata: page_number, process_number; tuser: command
// rsp      out  rsp_tvalid/tready    tdata: hit, evicted_valid, evicted_page,
//                                           evicted_process, occupancy
// csr      in   csr_valid/csr_ready  csr_data: capacity
//
// A request is taken in IDLE; in SCAN a single key comparator walks the key RAM
// one slot per cycle, and in UPDATE ranks are adjusted and, on an insertion, the
// new key is written into the RAM.
// Reset clears all slots and sets capacity to MAX_ENTRIES; no clearing pass.
// A response waits in its output register; the next request may be taken and
// scanned meanwhile, and only its UPDATE state stalls until rsp_tready.

module lru_page_replacement_list
   import lru_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // [19:0] page_number, [29:20] process_number, rest zero
   input  wire logic [REQ_BITS-1:0] req_tdata,
   // [0] command
   input  wire logic [0:0]          req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // [0] hit, [1] evicted_valid, [21:2] evicted_page, [31:22] evicted_process,
   // [36:32] occupancy, rest zero
   output logic [RSP_BITS-1:0]      rsp_tdata,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CAP_BITS-1:0] csr_data
);

   state_type state_ff, state_in;

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_BITS-1:0]    rank_ff [MAX_ENTRIES];
   logic [IDX_BITS-1:0]    rank_in [MAX_ENTRIES];
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CAP_BITS-1:0]    cap_ff;

   logic                cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [IDX_BITS-1:0] cmp_slot_ff;

   logic                match_found_ff, match_found_in;
   logic [IDX_BITS-1:0] match_slot_ff, match_slot_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_BITS-1:0] free_slot_ff, free_slot_in;
   logic                lru_found_ff, lru_found_in;
   logic [IDX_BITS-1:0] lru_slot_ff, lru_slot_in;
   logic [KEY_BITS-1:0] ev_key_ff, ev_key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_ev_ff, rsp_ev_in;
   logic [KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [OCC_BITS-1:0] rsp_occ_ff, rsp_occ_in;

   logic [IDX_BITS-1:0] rd_addr;
   logic [KEY_BITS-1:0] rd_data;
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr;

   logic                req_fire;
   logic                rsp_free;
   logic [CNT_BITS-1:0] eff_cap;
   logic                slot_valid;
   logic [IDX_BITS-1:0] match_rank;
   logic                evict;
   logic [IDX_BITS-1:0] ins_rank;

   lru_ram #(
      .WIDTH(KEY_BITS),
      .DEPTH(MAX_ENTRIES)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(key_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tdata  = RSP_BITS'({rsp_occ_ff, rsp_key_ff, rsp_ev_ff, rsp_hit_ff});
   assign rd_addr    = idx_ff[IDX_BITS-1:0];
   assign slot_valid = valid_ff[cmp_slot_ff];
   assign match_rank = rank_ff[match_slot_ff];

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_BITS'(1);
      end else if (int'(cap_ff) > MAX_ENTRIES) begin
         eff_cap = CNT_BITS'(MAX_ENTRIES);
      end else begin
         eff_cap = CNT_BITS'(cap_ff);
      end
   end

   // Scan: one slot compared per cycle against the registered RAM output.
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cmp_valid_in   = 1'b0;
      match_found_in = match_found_ff;
      match_slot_in  = match_slot_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      lru_found_in   = lru_found_ff;
      lru_slot_in    = lru_slot_ff;
      ev_key_in      = ev_key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in       = ST_SCAN;
               idx_in         = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               lru_found_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = (int'(idx_ff) < MAX_ENTRIES);
            idx_in       = idx_ff + CNT_BITS'(1);
            if (cmp_valid_ff) begin
               if (slot_valid && rd_data == key_ff && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_slot_in  = cmp_slot_ff;
               end
               if (!slot_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = cmp_slot_ff;
               end
               if (slot_valid && rank_ff[cmp_slot_ff] == '0 && !lru_found_ff) begin
                  lru_found_in = 1'b1;
                  lru_slot_in  = cmp_slot_ff;
                  ev_key_in    = rd_data;
               end
            end
            if (int'(idx_ff) == MAX_ENTRIES) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Update: rank adjustments are independent per slot.
   always_comb begin
      valid_in     = valid_ff;
      rank_in      = rank_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = free_slot_ff;
      evict        = 1'b0;
      ins_rank     = count_ff[IDX_BITS-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_occ_in   = rsp_occ_ff;
      if (state_ff == ST_UPDATE && rsp_free) begin
         if (cmd_ff == CMD_REMOVE) begin
            if (match_found_ff) begin
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (valid_ff[i] && rank_ff[i] > match_rank) begin
                     rank_in[i] = rank_ff[i] - IDX_BITS'(1);
                  end
               end
               valid_in[match_slot_ff] = 1'b0;
               rank_in[match_slot_ff]  = '0;
               count_in = count_ff - CNT_BITS'(1);
            end
         end else if (match_found_ff) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_ff[i] && rank_ff[i] > match_rank) begin
                  rank_in[i] = rank_ff[i] - IDX_BITS'(1);
               end
            end
            rank_in[match_slot_ff] = IDX_BITS'(count_ff - CNT_BITS'(1));
         end else begin
            evict = (count_ff >= eff_cap) && lru_found_ff;
            if (evict) begin
               // Drop the least recent page; every other page moves down one rank.
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (valid_ff[i] && rank_ff[i] != '0) begin
                     rank_in[i] = rank_ff[i] - IDX_BITS'(1);
                  end
               end
               valid_in[lru_slot_ff] = 1'b0;
               rank_in[lru_slot_ff]  = '0;
               ins_rank = IDX_BITS'(count_ff - CNT_BITS'(1));
               if (!(free_found_ff && free_slot_ff < lru_slot_ff)) begin
                  wr_addr = lru_slot_ff;
               end
               wr_en = 1'b1;
            end else if (free_found_ff) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_BITS'(1);
            end
            if (wr_en) begin
               valid_in[wr_addr] = 1'b1;
               rank_in[wr_addr]  = ins_rank;
            end
         end
         rsp_valid_in = 1'b1;
         rsp_hit_in   = match_found_ff;
         rsp_ev_in    = evict;
         rsp_key_in   = evict ? ev_key_ff : '0;
         rsp_occ_in   = OCC_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         count_ff       <= '0;
         cap_ff         <= CAP_RESET;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         lru_found_ff   <= 1'b0;
         idx_ff         <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         count_ff       <= count_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         lru_found_ff   <= lru_found_in;
         idx_ff         <= idx_in;
         rank_ff        <= rank_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_tuser[0];
         key_ff <= req_tdata[KEY_BITS-1:0];
      end
      cmp_slot_ff   <= idx_ff[IDX_BITS-1:0];
      match_slot_ff <= match_slot_in;
      free_slot_ff  <= free_slot_in;
      lru_slot_ff   <= lru_slot_in;
      ev_key_ff     <= ev_key_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

endmodule

`default_nettype wire
